// ===== sv/hcps_pkg.sv =====
// Shared types, constants and helpers for the half-complex power spectrum block.
`default_nettype none

package hcps_pkg;

  // Width of the half-length register and of bin numbers
  localparam int HALF_W = 10;
  // Width of the frame length N = 2M
  localparam int N_W = HALF_W + 1;
  // Largest M the register can hold
  localparam int HALF_MAX = (1 << HALF_W) - 1;
  localparam logic [HALF_W-1:0] HALF_RESET = 10'd512;

  // Defaults for top-level parameters
  localparam int MAX_HALF_LENGTH_DEF = 512;
  localparam int SAMPLE_WIDTH_DEF = 24;

  // Depth of the queue between front and back
  localparam int Q_DEPTH_DEF = 4;
  // Quotient bits resolved per divider stage
  localparam int DIV_BITS = 4;

  // Frame settings handed from the register to front and back
  typedef struct packed {
    logic              restart;
    logic [HALF_W-1:0] half;
    logic [N_W-1:0]    frame_len;
  } hcps_cfg_t;

  // Largest usable M for a given store depth
  function automatic int hcps_max_m(int max_half);
    return (max_half > HALF_MAX) ? HALF_MAX : max_half;
  endfunction

endpackage

`default_nettype wire

// ===== sv/hcps_queue.sv =====
// Small first-in first-out queue of words between the front and the back.
`default_nettype none

module hcps_queue
  import hcps_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = Q_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic                       pop,
  output logic      [WIDTH-1:0]           rdata,
  output logic                            empty,
  output logic                            full,
  output logic      [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == CNT_W'(DEPTH));
  assign count   = count_r;
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (!do_push && do_pop) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/hcps_front.sv =====
// Front end: frame position, real-part store, classification and squaring.
`default_nettype none

module hcps_front
  import hcps_pkg::*;
#(
  parameter int MAX_HALF_LENGTH = MAX_HALF_LENGTH_DEF,
  parameter int SAMPLE_WIDTH    = SAMPLE_WIDTH_DEF,
  parameter int Q_DEPTH         = Q_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire hcps_cfg_t                    cfg,
  input  wire logic                         in_push,
  output logic                              in_full,
  input  wire logic [SAMPLE_WIDTH-1:0]      in_coefficient,
  input  wire logic [$clog2(Q_DEPTH+1)-1:0] q_count,
  output logic                              q_push,
  output logic      [2*SAMPLE_WIDTH-1:0]    q_energy,
  output logic      [HALF_W-1:0]            q_bin,
  output logic                              q_last
);

  localparam int MAX_M  = hcps_max_m(MAX_HALF_LENGTH);
  localparam int POS_W  = $clog2(2 * MAX_M);
  localparam int AW     = (MAX_M > 1) ? $clog2(MAX_M) : 1;
  localparam int SQ_W   = 2 * SAMPLE_WIDTH - 1;
  localparam int E_W    = 2 * SAMPLE_WIDTH;
  localparam int QCNT_W = $clog2(Q_DEPTH + 1);
  localparam int CR_W   = QCNT_W + 1;

  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic [SAMPLE_WIDTH-1:0] store_mem [MAX_M];
  logic [SAMPLE_WIDTH-1:0] rd_data_r;

  // Stage 1: classified word and store read
  logic                    s1_v_r, s1_use_store_r, s1_last_r;
  logic [SAMPLE_WIDTH-1:0] s1_coef_r;
  logic [HALF_W-1:0]       s1_bin_r;
  // Stage 2: squares
  logic                    s2_v_r, s2_last_r;
  logic [SQ_W-1:0]         s2_sq_re_r, s2_sq_im_r;
  logic [HALF_W-1:0]       s2_bin_r;

  logic                    accept;
  logic [N_W-1:0]          p_raw, p_n, m_n, k_n, p_inc;
  logic                    is_edge, is_low, is_last, emit, st_we;
  logic [HALF_W-1:0]       bin;
  logic [CR_W-1:0]         credit_used;
  logic signed [E_W-1:0]   prod_re, prod_im;
  logic [SAMPLE_WIDTH-1:0] re_sel;

  // Queue credit: words in the queue plus words still in the pipe
  assign credit_used = CR_W'(q_count) + CR_W'(s1_v_r) + CR_W'(s2_v_r);
  assign in_full     = (credit_used >= CR_W'(Q_DEPTH));
  assign accept      = in_push && !in_full;

  // Position decode for the current word
  always_comb begin
    p_raw   = N_W'(pos_r);
    p_n     = (p_raw >= cfg.frame_len) ? '0 : p_raw;
    m_n     = N_W'(cfg.half);
    k_n     = cfg.frame_len - p_n;
    p_inc   = p_n + N_W'(1);
    is_edge = (p_n == '0) || (p_n == m_n);
    is_low  = (p_n < m_n);
    is_last = (p_n == cfg.frame_len - N_W'(1));
    emit    = is_edge || !is_low;
    st_we   = accept && is_low && !is_edge;
    bin     = is_edge ? HALF_W'(p_n) : HALF_W'(k_n);
    pos_nxt = (p_inc >= cfg.frame_len) ? '0 : POS_W'(p_inc);
  end

  // Frame position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (cfg.restart) begin
      pos_r <= '0;
    end else if (accept) begin
      pos_r <= pos_nxt;
    end
  end

  // Real-part store: written on the lower half, read back for the upper half
  always_ff @(posedge clk) begin
    if (st_we) begin
      store_mem[p_n[AW-1:0]] <= in_coefficient;
    end
    rd_data_r <= store_mem[k_n[AW-1:0]];
  end

  // Pipe valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept && emit;
      s2_v_r <= s1_v_r;
    end
  end

  // Squaring, real part zero at the edge bins
  always_comb begin
    re_sel  = s1_use_store_r ? rd_data_r : '0;
    prod_re = $signed(re_sel) * $signed(re_sel);
    prod_im = $signed(s1_coef_r) * $signed(s1_coef_r);
  end

  // Pipe payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_coef_r      <= in_coefficient;
      s1_use_store_r <= !is_edge;
      s1_bin_r       <= bin;
      s1_last_r      <= is_last;
    end
    s2_sq_re_r <= prod_re[SQ_W-1:0];
    s2_sq_im_r <= prod_im[SQ_W-1:0];
    s2_bin_r   <= s1_bin_r;
    s2_last_r  <= s1_last_r;
  end

  // Energy sum into the queue
  assign q_push   = s2_v_r;
  assign q_energy = E_W'(s2_sq_re_r) + E_W'(s2_sq_im_r);
  assign q_bin    = s2_bin_r;
  assign q_last   = s2_last_r;

endmodule

`default_nettype wire

// ===== sv/hcps_back.sv =====
// Back end: pipelined long division of the energy by the frame length.
`default_nettype none

module hcps_back
  import hcps_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire hcps_cfg_t                   cfg,
  input  wire logic                        q_empty,
  input  wire logic [2*SAMPLE_WIDTH-1:0]   q_energy,
  input  wire logic [HALF_W-1:0]           q_bin,
  input  wire logic                        q_last,
  output logic                             q_pop,
  output logic                             out_empty,
  input  wire logic                        out_pop,
  output logic      [2*SAMPLE_WIDTH-2:0]   out_power,
  output logic      [HALF_W-1:0]           out_bin_index,
  output logic                             out_last_bin
);

  localparam int E_W     = 2 * SAMPLE_WIDTH;
  localparam int POWER_W = 2 * SAMPLE_WIDTH - 1;
  localparam int STAGES  = (E_W + DIV_BITS - 1) / DIV_BITS;
  localparam int WK_W    = STAGES * DIV_BITS;

  // Dividend bits still to shift out, quotient bits shifted in at the bottom
  typedef struct packed {
    logic [WK_W-1:0] work;
    logic [N_W-1:0]  rem;
  } div_t;

  // Several restoring division steps on a narrow remainder
  function automatic div_t div_steps(div_t a, logic [N_W-1:0] d);
    div_t        r;
    logic [N_W:0] part;
    int          i;
    r = a;
    for (i = 0; i < DIV_BITS; i++) begin
      part   = {r.rem, r.work[WK_W-1]};
      r.work = {r.work[WK_W-2:0], 1'b0};
      if (part >= {1'b0, d}) begin
        r.rem     = N_W'(part - {1'b0, d});
        r.work[0] = 1'b1;
      end else begin
        r.rem = part[N_W-1:0];
      end
    end
    return r;
  endfunction

  logic              st_v_r    [STAGES];
  div_t              st_div_r  [STAGES];
  logic [HALF_W-1:0] st_bin_r  [STAGES];
  logic              st_last_r [STAGES];
  logic              adv, take;
  div_t              head;

  // Whole pipe moves unless the result word is held
  assign adv   = !st_v_r[STAGES-1] || out_pop;
  assign take  = adv && !q_empty;
  assign q_pop = take;

  assign head.work = WK_W'(q_energy);
  assign head.rem  = '0;

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STAGES; i++) begin
        st_v_r[i] <= 1'b0;
      end
    end else if (adv) begin
      st_v_r[0] <= take;
      for (int i = 1; i < STAGES; i++) begin
        st_v_r[i] <= st_v_r[i-1];
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (adv) begin
      st_div_r[0]  <= div_steps(head, cfg.frame_len);
      st_bin_r[0]  <= q_bin;
      st_last_r[0] <= q_last;
      for (int i = 1; i < STAGES; i++) begin
        st_div_r[i]  <= div_steps(st_div_r[i-1], cfg.frame_len);
        st_bin_r[i]  <= st_bin_r[i-1];
        st_last_r[i] <= st_last_r[i-1];
      end
    end
  end

  // Result word
  assign out_empty     = !st_v_r[STAGES-1];
  assign out_power     = st_div_r[STAGES-1].work[POWER_W-1:0];
  assign out_bin_index = st_bin_r[STAGES-1];
  assign out_last_bin  = st_last_r[STAGES-1];

endmodule

`default_nettype wire

// ===== sv/half_complex_power_spectrum.sv =====
// Top level of the half-complex power spectrum block.
//
// Input words are half-complex coefficients r0..rM, iM-1..i1 of one frame of
// N = 2M samples, pushed with in_push while in_full is low. One word is taken
// per cycle; in_full rises only when the result side backs up and the queue
// between front and back has no free credit left.
// Result words (power, bin_index, last_bin) leave in the order 0, M, M-1..1;
// a word waits on the out_ ports while out_empty is low and leaves on out_pop.
// Bins 1..M-1 pair the incoming imaginary part with the real part kept in an
// on-chip store; the other lower-half samples give no result.
// On its way to the out_ ports a word passes two front stages (store read,
// squaring), the queue write, then one divider stage per four quotient bits.
// When out_pop stays low the divider pipe holds, the queue fills and in_full
// rises; no word is lost.
// cfg_we writes M (cfg_half_length) and restarts the frame; M is taken as
// 1 when zero and is capped at the store depth. Write only while idle.
// Synchronous reset sets M to 512, the frame position to zero and empties
// all stages; the real store needs no clearing.
`default_nettype none

module half_complex_power_spectrum
  import hcps_pkg::*;
#(
  parameter int MAX_HALF_LENGTH = MAX_HALF_LENGTH_DEF,
  parameter int SAMPLE_WIDTH    = SAMPLE_WIDTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_push,
  output logic                           in_full,
  input  wire logic [SAMPLE_WIDTH-1:0]   in_coefficient,
  output logic                           out_empty,
  input  wire logic                      out_pop,
  output logic      [2*SAMPLE_WIDTH-2:0] out_power,
  output logic      [HALF_W-1:0]         out_bin_index,
  output logic                           out_last_bin,
  input  wire logic                      cfg_we,
  input  wire logic [HALF_W-1:0]         cfg_half_length
);

  localparam int MAX_M  = hcps_max_m(MAX_HALF_LENGTH);
  localparam int E_W    = 2 * SAMPLE_WIDTH;
  localparam int QW     = E_W + HALF_W + 1;
  localparam int QCNT_W = $clog2(Q_DEPTH_DEF + 1);

  logic [HALF_W-1:0] half_length_r;
  logic [HALF_W-1:0] eff_half;
  hcps_cfg_t         cfg;

  logic              q_push, q_pop, q_empty, q_full;
  logic [QCNT_W-1:0] q_count;
  logic [E_W-1:0]    f_energy, b_energy;
  logic [HALF_W-1:0] f_bin, b_bin;
  logic              f_last, b_last;
  logic [QW-1:0]     q_wdata, q_rdata;

  // Half-length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_length_r <= HALF_RESET;
    end else if (cfg_we) begin
      half_length_r <= cfg_half_length;
    end
  end

  // Saturate M to the usable range
  always_comb begin
    if (half_length_r == '0) begin
      eff_half = HALF_W'(1);
    end else if (half_length_r > HALF_W'(MAX_M)) begin
      eff_half = HALF_W'(MAX_M);
    end else begin
      eff_half = half_length_r;
    end
    cfg.restart   = cfg_we;
    cfg.half      = eff_half;
    cfg.frame_len = {eff_half, 1'b0};
  end

  hcps_front #(
    .MAX_HALF_LENGTH(MAX_HALF_LENGTH),
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .Q_DEPTH        (Q_DEPTH_DEF)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_coefficient(in_coefficient),
    .q_count       (q_count),
    .q_push        (q_push),
    .q_energy      (f_energy),
    .q_bin         (f_bin),
    .q_last        (f_last)
  );

  assign q_wdata = {f_energy, f_bin, f_last};

  hcps_queue #(
    .WIDTH(QW),
    .DEPTH(Q_DEPTH_DEF)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_wdata),
    .pop  (q_pop),
    .rdata(q_rdata),
    .empty(q_empty),
    .full (q_full),
    .count(q_count)
  );

  assign {b_energy, b_bin, b_last} = q_rdata;

  hcps_back #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .q_empty      (q_empty),
    .q_energy     (b_energy),
    .q_bin        (b_bin),
    .q_last       (b_last),
    .q_pop        (q_pop),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_power    (out_power),
    .out_bin_index(out_bin_index),
    .out_last_bin (out_last_bin)
  );

  // Credit scheme must never push into a full queue
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("word pushed into full queue");

  // Final word of a frame is always bin one
  a_last_is_bin_one: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_last_bin) |-> (out_bin_index == HALF_W'(1)))
    else $error("last word carries wrong bin");

endmodule

`default_nettype wire

// ===== bench/half_complex_power_spectrum_tb.sv =====
// Self-checking bench for the half-complex power spectrum block: table, random frames, scoreboard.
module half_complex_power_spectrum_tb
  import hcps_pkg::*;
();

  localparam int SW          = SAMPLE_WIDTH_DEF;
  localparam int POW_W       = 2 * SAMPLE_WIDTH_DEF - 1;
  localparam int STORE_DEPTH = MAX_HALF_LENGTH_DEF;
  localparam int LATENCY     = 14;
  localparam int RANDOM_WORDS = 1550;
  localparam int PAUSE_AT     = 500;
  localparam int STEADY_FROM  = 900;
  localparam int STEADY_TO    = 1150;

  typedef enum logic {ROW_CFG, ROW_WORD} row_kind_t;

  typedef struct packed {
    logic [POW_W-1:0]  power;
    logic [HALF_W-1:0] bin;
    logic              last;
  } bin_word_t;

  typedef struct packed {
    row_kind_t     kind;
    logic [SW-1:0] value;
    logic          typed;
    bin_word_t     want;
  } stim_row_t;

  // Directed table: extremes, M = 1 (also from a zero write), M = 3, restart mid-frame,
  // saturating write. Typed results only where the arithmetic is obvious.
  localparam stim_row_t DIRECTED [25] = '{
    '{ROW_WORD, 24'h800000, 1'b1, '{47'd68719476736, 10'd0, 1'b0}},
    '{ROW_WORD, 24'h7FFFFF, 1'b0, '0},
    '{ROW_CFG,  24'd0,      1'b0, '0},
    '{ROW_WORD, 24'h7FFFFF, 1'b1, '{47'd35184363700224, 10'd0, 1'b0}},
    '{ROW_WORD, 24'h800000, 1'b1, '{47'd35184372088832, 10'd1, 1'b1}},
    '{ROW_CFG,  24'd1,      1'b0, '0},
    '{ROW_WORD, 24'h000000, 1'b1, '{47'd0, 10'd0, 1'b0}},
    '{ROW_WORD, 24'hFFFFFF, 1'b1, '{47'd0, 10'd1, 1'b1}},
    '{ROW_CFG,  24'd3,      1'b0, '0},
    '{ROW_WORD, 24'h000005, 1'b0, '0},
    '{ROW_WORD, 24'h800000, 1'b0, '0},
    '{ROW_WORD, 24'h7FFFFF, 1'b0, '0},
    '{ROW_WORD, 24'h555555, 1'b0, '0},
    '{ROW_WORD, 24'hAAAAAA, 1'b0, '0},
    '{ROW_WORD, 24'h800000, 1'b0, '0},
    '{ROW_CFG,  24'd2,      1'b0, '0},
    '{ROW_WORD, 24'h123456, 1'b0, '0},
    '{ROW_WORD, 24'h654321, 1'b0, '0},
    '{ROW_CFG,  24'd2,      1'b0, '0},
    '{ROW_WORD, 24'h000001, 1'b0, '0},
    '{ROW_WORD, 24'hFEDCBA, 1'b0, '0},
    '{ROW_WORD, 24'h400000, 1'b0, '0},
    '{ROW_WORD, 24'h7FFFFF, 1'b0, '0},
    '{ROW_CFG,  24'd1023,   1'b0, '0},
    '{ROW_WORD, 24'h800000, 1'b1, '{47'd68719476736, 10'd0, 1'b0}}
  };

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_push = 1'b0;
  logic              in_full;
  logic [SW-1:0]     in_coefficient = '0;
  logic              out_empty;
  logic              out_pop = 1'b0;
  logic [POW_W-1:0]  out_power;
  logic [HALF_W-1:0] out_bin_index;
  logic              out_last_bin;
  logic              cfg_we = 1'b0;
  logic [HALF_W-1:0] cfg_half_length = '0;

  half_complex_power_spectrum DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_coefficient (in_coefficient),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_power      (out_power),
    .out_bin_index  (out_bin_index),
    .out_last_bin   (out_last_bin),
    .cfg_we         (cfg_we),
    .cfg_half_length(cfg_half_length)
  );

  // Spectrum model state
  logic [SW-1:0]     real_store [0:STORE_DEPTH-1];
  int unsigned       frame_pos = 0;
  logic [HALF_W-1:0] half_reg = HALF_RESET;

  bin_word_t pending_bins [$];

  bit steady = 1'b0;
  int errors = 0;
  int words_sent = 0;
  int bins_checked = 0;
  int cfg_writes = 0;
  int random_words = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Square of a two's complement sample, exact
  function automatic longint unsigned square_word(input logic [SW-1:0] v);
    logic [SW-1:0]     mag;
    longint unsigned   wide;
    mag = v[SW-1] ? -v : v;
    wide = mag;
    return wide * wide;
  endfunction

  // Advance the frame by one coefficient; returns 1 when a power bin is due
  function automatic bit spectrum_step(input logic [SW-1:0] w, output bin_word_t r);
    int unsigned     m;
    int unsigned     n;
    int unsigned     p;
    int unsigned     k;
    longint unsigned energy;
    bit              hit;
    m = half_reg;
    if (m < 1) m = 1;
    if (m > STORE_DEPTH) m = STORE_DEPTH;
    n = 2 * m;
    p = frame_pos;
    if (p >= n) p = 0;
    hit = 1'b1;
    k = p;
    energy = 0;
    r = '0;
    if (p == 0 || p == m) begin
      energy = square_word(w);
    end else if (p < m) begin
      real_store[p] = w;
      hit = 1'b0;
    end else begin
      k = n - p;
      energy = square_word(real_store[k]) + square_word(w);
    end
    if (hit) begin
      r.power = POW_W'(energy / n);
      r.bin   = HALF_W'(k);
      r.last  = (p == n - 1);
    end
    frame_pos = (p + 1 >= n) ? 0 : p + 1;
    return hit;
  endfunction

  // Push one word; the model runs at the accepting edge
  task automatic send_word(input logic [SW-1:0] w, input bit typed, input bin_word_t want);
    bin_word_t got;
    if (!steady && $urandom_range(0, 99) < 20) begin
      in_push <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 30);
    end
    in_push <= 1'b1;
    in_coefficient <= w;
    @(posedge clk);
    while (in_full !== 1'b0) @(posedge clk);
    if (spectrum_step(w, got)) pending_bins.push_back(typed ? want : got);
    words_sent++;
  endtask

  // Hold the sender until every expected bin has left, then idle a while
  task automatic settle_queue(input int extra);
    in_push <= 1'b0;
    do @(posedge clk); while (pending_bins.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_half(input logic [HALF_W-1:0] v);
    settle_queue(LATENCY + 6);
    cfg_we <= 1'b1;
    cfg_half_length <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    half_reg = v;
    frame_pos = 0;
    cfg_writes++;
  endtask

  function automatic logic [SW-1:0] random_coefficient();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return {1'b1, {(SW-1){1'b0}}};
      1: return {1'b0, {(SW-1){1'b1}}};
      2: return SW'($urandom_range(0, 31) - 16);
      3: return '0;
      default: return SW'($urandom);
    endcase
  endfunction

  // One random word, with the gap-free steady stretch and the mid-frame drain
  task automatic random_word();
    steady = (random_words >= STEADY_FROM && random_words < STEADY_TO);
    if (random_words == PAUSE_AT) settle_queue(0);
    send_word(random_coefficient(), 1'b0, '0);
    random_words++;
  endtask

  // Result side: random pops, occasional long stalls, scoreboard compare
  initial begin : drain_side
    int stall_left;
    bin_word_t want;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && out_empty === 1'b0) begin
        if (pending_bins.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected word: power=%0d bin=%0d last=%0b",
                     out_power, out_bin_index, out_last_bin);
        end else begin
          want = pending_bins.pop_front();
          bins_checked++;
          if (out_power !== want.power || out_bin_index !== want.bin ||
              out_last_bin !== want.last) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected power=%0d bin=%0d last=%0b, got %0d %0d %0b",
                       want.power, want.bin, want.last,
                       out_power, out_bin_index, out_last_bin);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_pop <= 1'b0;
      end else if (!steady && $urandom_range(0, 499) < 1) begin
        stall_left = $urandom_range(10, 40);
        out_pop <= 1'b0;
      end else begin
        out_pop <= steady || ($urandom_range(0, 99) >= 18);
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    int cfg;
    int m_eff;
    int frames;
    int sel;
    bit big_done;
    big_done = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_CFG)
        write_half(HALF_W'(DIRECTED[i].value));
      else
        send_word(DIRECTED[i].value, DIRECTED[i].typed, DIRECTED[i].want);
    end

    // Random phases: mostly short frames, one frame at the full store depth
    while (random_words < RANDOM_WORDS) begin
      sel = $urandom_range(0, 99);
      if (!big_done && random_words > 400) begin
        cfg = $urandom_range(STORE_DEPTH, HALF_MAX);
        big_done = 1'b1;
      end else if (sel < 70) begin
        cfg = $urandom_range(0, 8);
      end else if (sel < 90) begin
        cfg = $urandom_range(9, 40);
      end else begin
        cfg = $urandom_range(41, 100);
      end
      write_half(HALF_W'(cfg));
      m_eff = (cfg == 0) ? 1 : ((cfg > STORE_DEPTH) ? STORE_DEPTH : cfg);
      frames = (m_eff > 40) ? 1 : $urandom_range(1, 4);
      repeat (frames * 2 * m_eff) random_word();
      // sometimes leave a frame unfinished; the next write restarts it
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2 * m_eff - 1)) random_word();
    end

    steady = 1'b0;
    settle_queue(LATENCY + 10);
    if (pending_bins.size() != 0) begin
      errors += pending_bins.size();
      $display("%0d expected bins never arrived", pending_bins.size());
    end
    $display("Sent %0d coefficient words over %0d half-length writes (zero and saturating",
             words_sent, cfg_writes);
    $display("values included); checked %0d power bins.", bins_checked);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d errors", errors);
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("timeout with %0d bins outstanding", pending_bins.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
